>>> hw/rtl/dgn_pkg.sv
// Package for the depth to gray normalizer: codes, fixed-point constants,
// the queue entry type and the back-end state type.
// No dependencies.
package dgn_pkg;

    // opcode field
    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    // depth_encoding register values
    localparam logic ENC_MM    = 1'b0;
    localparam logic ENC_FLOAT = 1'b1;

    // register index of depth_encoding
    localparam logic REG_DEPTH_ENCODING = 1'b0;

    // mm to Q16.16: q = floor(mm * 8192 / 125) via reciprocal and one correction
    localparam int          MM_LSH     = 13;
    localparam int          MM_RSH     = 23;
    localparam logic [29:0] MM_RECIP   = 30'd549755813;
    localparam logic [29:0] MM_DIVISOR = 30'd125;

    // float exponent thresholds
    localparam logic [7:0] FLT_EXP_SPECIAL = 8'd255;
    localparam logic [7:0] FLT_EXP_SAT     = 8'd143;
    localparam logic [7:0] FLT_EXP_UNITY   = 8'd134;

    localparam logic [31:0] DEPTH_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [7:0]  GRAY_MAX       = 8'd255;
    localparam logic [7:0]  GRAY_ZERO      = 8'd0;

    typedef struct packed {
        logic        ok;
        logic [31:0] v;
        logic [31:0] dmin;
        logic [31:0] dmax;
    } t_qent;

    typedef struct packed {
        logic  vld;
        t_qent ent;
    } t_push;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SPAN,
        B_NUM,
        B_SCALE,
        B_DIV,
        B_DONE
    } t_bstate;

endpackage

>>> hw/rtl/depth_to_gray_normalizer_unit.sv
// Measure pixels: one per cycle through a 3-stage front, unless a convert
// pixel ahead waits on a full queue; no result. Convert pixels: the back end
// passes each through the radix-2 divider, skipping the divide when the pixel
// is invalid or outside the measured range, and takes one pixel at a time.
// Synchronous active-low reset clears the pipeline, queue, min/max tracking
// (min all ones, max zero) and the encoding register (millimetres).
module depth_to_gray_normalizer_unit import dgn_pkg::*; #(
    parameter int MIN_SPAN    = 7,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] raw_depth
    input  logic [1:0]  s_axis_tuser,   // [0] opcode, [1] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] gray_level
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic   r_enc;
    t_push  push;
    t_qstat qstat;
    t_qent  head;
    logic   pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DEPTH_ENCODING) ? {31'd0, r_enc} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc <= ENC_MM;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_DEPTH_ENCODING) begin
            r_enc <= pwdata[0];
        end
    end

    dgn_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_enc    (r_enc),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_opcode (s_axis_tuser[0]),
        .i_fstart (s_axis_tuser[1]),
        .i_raw    (s_axis_tdata),
        .i_qstat  (qstat),
        .o_push   (push)
    );

    dgn_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_qstat (qstat),
        .o_head  (head)
    );

    dgn_back #(.MIN_SPAN(MIN_SPAN)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (qstat),
        .i_head   (head),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

endmodule

>>> hw/rtl/dgn_front.sv
// Front end: accepts pixels, converts raw words to Q16.16 metres, tracks
// min/max over measure pixels and pushes convert pixels to the queue.
// Depends on dgn_pkg.
module dgn_front import dgn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_enc,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic        i_fstart,
    input  logic [31:0] i_raw,
    input  t_qstat      i_qstat,
    output t_push       o_push
);

    // stage 1: captured input
    logic        r_f1_vld, r_f1_op, r_f1_fs, r_f1_enc;
    logic [31:0] r_f1_raw;
    // stage 2: product and float result
    logic        r_f2_vld, r_f2_op, r_f2_fs, r_f2_enc, r_f2_ok;
    logic [15:0] r_f2_mm;
    logic [45:0] r_f2_prod;
    logic [31:0] r_f2_fq;
    // stage 3: depth ready
    logic        r_f3_vld, r_f3_op, r_f3_fs, r_f3_ok;
    logic [31:0] r_f3_v;
    // tracking
    logic [31:0] r_min, r_max;

    logic        f3_go, f3_free, f2_free, f1_free;
    logic        sgn;
    logic [7:0]  expo, rs;
    logic [22:0] mant;
    logic [31:0] sig32, fq;
    logic        ok;
    logic [22:0] q0;
    logic [29:0] lhs, rem;
    logic [31:0] v_mm;
    logic [31:0] base_min, base_max;

    assign f3_go   = r_f3_vld && (r_f3_op == OP_MEASURE || !i_qstat.full);
    assign f3_free = !r_f3_vld || f3_go;
    assign f2_free = !r_f2_vld || f3_free;
    assign f1_free = !r_f1_vld || f2_free;
    assign o_ready = f1_free;

    // float decode of stage 1 word
    always_comb begin
        sgn   = r_f1_raw[31];
        expo  = r_f1_raw[30:23];
        mant  = r_f1_raw[22:0];
        sig32 = {8'd0, 1'b1, mant};
        rs    = FLT_EXP_UNITY - expo;
        if (expo == 8'd0) begin
            fq = 32'd0;
        end else if (expo >= FLT_EXP_SAT) begin
            fq = DEPTH_ALL_ONES;
        end else if (expo >= FLT_EXP_UNITY) begin
            fq = sig32 << (expo - FLT_EXP_UNITY);
        end else if (rs >= 8'd32) begin
            fq = 32'd0;
        end else begin
            fq = sig32 >> rs[4:0];
        end
        if (r_f1_enc == ENC_FLOAT) begin
            ok = !sgn && expo != FLT_EXP_SPECIAL && !(expo == 8'd0 && mant == 23'd0);
        end else begin
            ok = r_f1_raw[15:0] != 16'd0;
        end
    end

    // reciprocal estimate is exact or one low: correct with the remainder
    always_comb begin
        q0   = r_f2_prod[45:MM_RSH];
        lhs  = {1'b0, r_f2_mm, 13'd0};
        rem  = lhs - 30'(q0) * MM_DIVISOR;
        v_mm = (rem >= MM_DIVISOR) ? 32'(q0) + 32'd1 : 32'(q0);
    end

    always_comb begin
        base_min = r_f3_fs ? DEPTH_ALL_ONES : r_min;
        base_max = r_f3_fs ? 32'd0 : r_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            r_f3_vld <= 1'b0;
            r_min    <= DEPTH_ALL_ONES;
            r_max    <= 32'd0;
        end else begin
            if (f1_free) begin
                r_f1_vld <= i_valid;
            end
            if (f2_free) begin
                r_f2_vld <= r_f1_vld;
            end
            if (f3_free) begin
                r_f3_vld <= r_f2_vld;
            end
            if (f3_go && r_f3_op == OP_MEASURE) begin
                r_min <= (r_f3_ok && r_f3_v < base_min) ? r_f3_v : base_min;
                r_max <= (r_f3_ok && r_f3_v > base_max) ? r_f3_v : base_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (f1_free && i_valid) begin
            r_f1_op  <= i_opcode;
            r_f1_fs  <= i_fstart;
            r_f1_raw <= i_raw;
            r_f1_enc <= i_enc;
        end
        if (f2_free && r_f1_vld) begin
            r_f2_op   <= r_f1_op;
            r_f2_fs   <= r_f1_fs;
            r_f2_enc  <= r_f1_enc;
            r_f2_ok   <= ok;
            r_f2_mm   <= r_f1_raw[15:0];
            r_f2_prod <= 46'(r_f1_raw[15:0]) * 46'(MM_RECIP);
            r_f2_fq   <= fq;
        end
        if (f3_free && r_f2_vld) begin
            r_f3_op <= r_f2_op;
            r_f3_fs <= r_f2_fs;
            r_f3_ok <= r_f2_ok;
            r_f3_v  <= (r_f2_enc == ENC_FLOAT) ? r_f2_fq : v_mm;
        end
    end

    // convert pixels carry the range seen so far
    assign o_push.vld      = f3_go && r_f3_op == OP_CONVERT;
    assign o_push.ent.ok   = r_f3_ok;
    assign o_push.ent.v    = r_f3_v;
    assign o_push.ent.dmin = r_min;
    assign o_push.ent.dmax = r_max;

endmodule

>>> hw/rtl/dgn_queue.sv
// Short queue of convert pixels between the front and back ends.
// Depends on dgn_pkg.
module dgn_queue import dgn_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output t_qstat o_qstat,
    output t_qent  o_head
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_qent           r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_qstat.empty = r_cnt == CW'(0);
    assign o_qstat.full  = r_cnt == CW'(DEPTH);
    assign do_push       = i_push.vld && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_head        = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.ent;
        end
    end

endmodule

>>> hw/rtl/dgn_back.sv
// Back end: computes span and offset, then an 8-step restoring divide for
// gray = floor(255*num/span), and holds the result in the output register.
// Depends on dgn_pkg.
module dgn_back import dgn_pkg::*; #(
    parameter int MIN_SPAN = 7
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_qstat     i_qstat,
    input  t_qent      i_head,
    output logic       o_pop,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata
);

    t_bstate            r_state, n_state;
    t_qent              r_ent;
    logic [31:0]        r_span;
    logic signed [32:0] r_d;
    logic [39:0]        r_rem, r_div;
    logic [7:0]         r_q, r_gray;
    logic [2:0]         r_cnt;
    logic               r_out_vld;
    logic [7:0]         r_out_data;

    logic        out_free, out_load;
    logic        d_le0, d_ge_span, ge;
    logic [32:0] diff;

    assign out_free  = !r_out_vld || i_tready;
    assign d_le0     = r_d[32] || r_d == 33'sd0;
    assign d_ge_span = !r_d[32] && r_d[31:0] >= r_span;
    assign ge        = r_rem >= r_div;
    assign diff      = {1'b0, r_ent.dmax} - {1'b0, r_ent.dmin};

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (!i_qstat.empty) n_state = B_SPAN;
            B_SPAN:  n_state = B_NUM;
            B_NUM: begin
                if (!r_ent.ok || d_le0 || d_ge_span) begin
                    n_state = B_DONE;
                end else begin
                    n_state = B_SCALE;
                end
            end
            B_SCALE: n_state = B_DIV;
            B_DIV:   if (r_cnt == 3'd0) n_state = B_DONE;
            B_DONE:  if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            B_IDLE:  o_pop = !i_qstat.empty;
            B_DONE:  out_load = out_free;
            default: begin
                o_pop    = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    r_ent <= i_head;
                end
            end
            B_SPAN: begin
                r_span <= (diff[32] || diff[31:0] < 32'(MIN_SPAN)) ? 32'(MIN_SPAN)
                                                                    : diff[31:0];
                r_d    <= $signed({1'b0, r_ent.v}) - $signed({1'b0, r_ent.dmin});
            end
            B_NUM: begin
                // at or below the minimum: full scale; invalid or beyond span: black
                r_gray <= (r_ent.ok && d_le0) ? GRAY_MAX : GRAY_ZERO;
                r_rem  <= 40'(r_span - r_d[31:0]);
            end
            B_SCALE: begin
                r_rem <= (r_rem << 8) - r_rem;
                r_div <= {1'b0, r_span, 7'd0};
                r_cnt <= 3'd7;
                r_q   <= 8'd0;
            end
            B_DIV: begin
                if (ge) begin
                    r_rem <= r_rem - r_div;
                end
                r_div <= r_div >> 1;
                r_q   <= {r_q[6:0], ge};
                r_cnt <= r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    r_gray <= {r_q[6:0], ge};
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_data <= r_gray;
        end
    end

    assign o_tvalid = r_out_vld;
    assign o_tdata  = r_out_data;

endmodule

>>> hw/rtl/dgn_checker.sv
// Port-level checks for the depth to gray normalizer, bound to the top level.
// Depends on dgn_pkg and depth_to_gray_normalizer_unit.
module dgn_checker import dgn_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    logic [15:0] r_pending;
    logic        conv_in, out_xfer;

    assign conv_in  = s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == OP_CONVERT;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // count convert transfers not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 16'd0;
        end else if (conv_in && !out_xfer) begin
            r_pending <= r_pending + 16'd1;
        end else if (out_xfer && !conv_in) begin
            r_pending <= r_pending - 16'd1;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != 16'd0)
        else $error("result without a pending convert pixel");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && paddr[2] == REG_DEPTH_ENCODING
        |=> paddr[2] != REG_DEPTH_ENCODING || prdata[0] == $past(pwdata[0]))
        else $error("encoding register readback mismatch");

endmodule

bind depth_to_gray_normalizer_unit dgn_checker u_dgn_checker (.*);

>>> verif/gray_level_checker.sv
// Checker for the depth to gray normalizer: watches the pixel, gray and APB channels,
// predicts each gray level from its own min/max tracking and compares in order.
// Depends on dgn_pkg for the opcode and encoding codes.
module gray_level_checker import dgn_pkg::*; #(
    parameter int MIN_SPAN = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,    // [31:0] raw_depth
    input  logic [1:0]  i_s_tuser,    // [0] opcode, [1] frame_start
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,    // [7:0] gray_level
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [2:0] ENC_ADDR      = {REG_DEPTH_ENCODING, 2'b00};
    localparam logic [7:0] EXP_SPECIAL   = 8'd255;
    localparam logic [7:0] EXP_SATURATE  = 8'd143;
    localparam logic [7:0] EXP_UNITY     = 8'd134;

    typedef struct packed {
        logic        ok;
        logic [31:0] q;
    } t_depth_q16;

    logic        encoding;
    logic [31:0] min_q16;
    logic [31:0] max_q16;
    logic [7:0]  gray_expected_q[$];

    // Raw pixel word to unsigned Q16.16 metres plus a validity flag.
    function automatic t_depth_q16 decode_depth(input logic enc, input logic [31:0] raw);
        t_depth_q16  d;
        logic [7:0]  expo;
        logic [63:0] sig;
        logic [47:0] scaled;
        int          rs;
        d.ok = 1'b0;
        d.q  = '0;
        if (enc == ENC_MM) begin
            scaled = {raw[15:0], 16'h0000};
            d.q    = 32'(scaled / 48'd1000);
            d.ok   = (raw[15:0] != 16'h0000);
            return d;
        end
        expo = raw[30:23];
        sig  = {40'h0, 1'b1, raw[22:0]};
        if (raw[31] || expo == EXP_SPECIAL || raw[30:0] == '0) begin
            return d;
        end
        d.ok = 1'b1;
        if (expo == 8'h00) begin
            d.q = '0;               // subnormal: valid but rounds to zero
        end else if (expo >= EXP_SATURATE) begin
            d.q = '1;
        end else if (expo >= EXP_UNITY) begin
            d.q = 32'(sig << (expo - EXP_UNITY));
        end else begin
            rs  = int'(EXP_UNITY) - int'(expo);
            d.q = (rs >= 32) ? '0 : 32'(sig >> rs);
        end
        return d;
    endfunction

    function automatic logic [7:0] predict_gray(input t_depth_q16 d);
        longint lo;
        longint hi;
        longint v;
        longint span;
        longint num;
        longint g;
        lo   = {32'h0, min_q16};
        hi   = {32'h0, max_q16};
        v    = {32'h0, d.q};
        span = hi - lo;
        if (span < MIN_SPAN) begin
            span = MIN_SPAN;
        end
        if (!d.ok) begin
            return 8'h00;
        end
        num = span - (v - lo);
        if (num <= 0) begin
            g = 0;
        end else begin
            g = (num * 255) / span;
            if (g > 255) begin
                g = 255;
            end
        end
        return 8'(g);
    endfunction

    always @(posedge i_clk) begin
        t_depth_q16 d;
        logic [7:0] want;
        if (!i_rst_n) begin
            encoding = ENC_MM;
            min_q16  = '1;
            max_q16  = '0;
            gray_expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ENC_ADDR) begin
                encoding = i_pwdata[0];
            end
            if (i_m_tvalid && i_m_tready) begin
                if (gray_expected_q.size() == 0) begin
                    $error("gray_level: expected no transfer, actual %0d", i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = gray_expected_q.pop_front();
                    if (i_m_tdata !== want) begin
                        $error("gray_level mismatch: expected %0d, actual %0d",
                               want, i_m_tdata);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                d = decode_depth(encoding, i_s_tdata);
                if (i_s_tuser[0] == OP_MEASURE) begin
                    // frame start clears tracking before this pixel counts
                    if (i_s_tuser[1]) begin
                        min_q16 = '1;
                        max_q16 = '0;
                    end
                    if (d.ok) begin
                        if (d.q < min_q16) begin
                            min_q16 = d.q;
                        end
                        if (d.q > max_q16) begin
                            max_q16 = d.q;
                        end
                    end
                end else begin
                    gray_expected_q.insert(gray_expected_q.size(), predict_gray(d));
                end
            end
        end
        o_pending <= gray_expected_q.size();
    end

endmodule

>>> verif/depth_to_gray_normalizer_unit_test.sv
// Testbench top for depth_to_gray_normalizer_unit: drives pixel frames in both depth
// encodings with bursty input and a stalling output, and reports the verdict.
// Depends on dgn_pkg, the unit and gray_level_checker.
module depth_to_gray_normalizer_unit_test;
    import dgn_pkg::*;

    localparam int         MIN_SPAN      = 7;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         SETTLE_CYCLES = 24;
    localparam int         PHASES        = 6;
    localparam int         PHASE_ITEMS   = 108;
    localparam logic [2:0] ENC_ADDR      = {REG_DEPTH_ENCODING, 2'b00};

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] raw_depth
    logic [1:0]  s_axis_tuser  = '0;   // [0] opcode, [1] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] gray_level
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          gray_pending;
    int          idle_cycles   = 0;
    int          burst_left    = 0;
    logic [1:0]  rx_mode       = '0;
    int          rx_left       = 0;

    logic        cur_encoding  = ENC_MM;
    int          win_mm_lo;
    int          win_mm_width;
    logic [7:0]  win_fexp;
    logic [22:0] win_fman;
    logic [22:0] win_fmask;

    always #2 i_clk = ~i_clk;

    depth_to_gray_normalizer_unit #(
        .MIN_SPAN (MIN_SPAN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    gray_level_checker #(
        .MIN_SPAN (MIN_SPAN)
    ) gray_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (gray_pending)
    );

    // Receiver: stretches of always ready, light stalls and heavy stalls.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= 2'($urandom_range(0, 2));
            rx_left <= $urandom_range(32, 256);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Abort when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("depth_to_gray_normalizer_unit verification failed");
            $finish;
        end
    end

    task automatic send_pixel(input logic op, input logic fs, input logic [31:0] raw);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        s_axis_tuser  <= {fs, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_encoding(input logic enc);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ENC_ADDR;
        pwdata  <= {31'h0, enc};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_encoding = enc;
    endtask

    // Wait for every gray level, then let the measure front settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (gray_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic new_window();
        win_mm_lo = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20)
                                                : $urandom_range(1, 65535);
        case ($urandom_range(0, 2))
            0:       win_mm_width = $urandom_range(0, 3);
            1:       win_mm_width = $urandom_range(0, 300);
            default: win_mm_width = $urandom_range(0, 65535);
        endcase
        win_fexp = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 253))
                                               : 8'($urandom_range(112, 142));
        win_fman = 23'($urandom());
        case ($urandom_range(0, 2))
            0:       win_fmask = 23'h00000F;
            1:       win_fmask = 23'h0003FF;
            default: win_fmask = 23'h7FFFFF;
        endcase
    endtask

    // Pixel near the current window, with some invalid and out-of-range words.
    function automatic logic [31:0] make_depth();
        int          pick;
        logic [7:0]  fexp;
        logic [15:0] mm;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            return $urandom();
        end
        if (cur_encoding == ENC_MM) begin
            if (pick == 1) begin
                return {16'($urandom()), 16'h0000};
            end
            mm = 16'(win_mm_lo + $urandom_range(0, win_mm_width));
            return {(pick < 6) ? 16'($urandom()) : 16'h0000, mm};
        end
        if (pick == 1) begin
            case ($urandom_range(0, 5))
                0:       return 32'h7F80_0000;
                1:       return {9'h0FF, 23'($urandom_range(1, 23'h7FFFFF))};
                2:       return {1'b1, 31'($urandom())};
                3:       return 32'h0000_0000;
                4:       return {9'h000, 23'($urandom())};
                default: return {1'b0, 8'($urandom_range(143, 254)), 23'($urandom())};
            endcase
        end
        fexp = win_fexp + (($urandom_range(0, 3) == 0) ? 8'd1 : 8'd0);
        if (fexp == 8'hFF) begin
            fexp = 8'hFE;
        end
        return {1'b0, fexp, win_fman ^ (23'($urandom()) & win_fmask)};
    endfunction

    task automatic run_directed();
        // millimetre mode from reset: nothing measured yet
        send_pixel(OP_CONVERT, 1'b0, 32'h0000_01F4);
        send_pixel(OP_CONVERT, 1'b0, 32'h0000_0000);
        // frame with upper bits set, the largest and the smallest distance
        send_pixel(OP_MEASURE, 1'b1, 32'hABCD_0000);
        send_pixel(OP_MEASURE, 1'b0, 32'hFFFF_03E8);
        send_pixel(OP_MEASURE, 1'b0, 32'h0000_FFFF);
        send_pixel(OP_MEASURE, 1'b0, 32'h0000_0001);
        send_pixel(OP_CONVERT, 1'b1, 32'h0000_0001);
        send_pixel(OP_CONVERT, 1'b0, 32'h0000_FFFF);
        send_pixel(OP_CONVERT, 1'b0, 32'h0000_03E8);
        send_pixel(OP_CONVERT, 1'b0, 32'h0000_0000);
        drain();
        write_encoding(ENC_FLOAT);
        // convert against the frame measured in millimetres
        send_pixel(OP_CONVERT, 1'b0, 32'h4000_0000);
        // infinity, NaN, negative zero, negative, subnormal, saturating, one metre
        send_pixel(OP_MEASURE, 1'b1, 32'h7F80_0000);
        send_pixel(OP_MEASURE, 1'b0, 32'h7FC0_0000);
        send_pixel(OP_MEASURE, 1'b0, 32'h8000_0000);
        send_pixel(OP_MEASURE, 1'b0, 32'hBF80_0000);
        send_pixel(OP_MEASURE, 1'b0, 32'h0000_0001);
        send_pixel(OP_MEASURE, 1'b0, 32'h4780_0000);
        send_pixel(OP_MEASURE, 1'b0, 32'h3F80_0000);
        send_pixel(OP_CONVERT, 1'b0, 32'h7F7F_FFFF);
        send_pixel(OP_CONVERT, 1'b0, 32'h0000_0001);
        send_pixel(OP_CONVERT, 1'b0, 32'h3F80_0000);
        send_pixel(OP_CONVERT, 1'b0, 32'hFF80_0000);
        send_pixel(OP_CONVERT, 1'b0, 32'h0000_0000);
        // single-pixel frame: span held at its floor, convert just past the range
        send_pixel(OP_MEASURE, 1'b1, 32'h3F80_0000);
        send_pixel(OP_CONVERT, 1'b0, 32'h3F80_0100);
        drain();
    endtask

    task automatic run_phase(input int n_items);
        int sent;
        int shape;
        int n_meas;
        int n_conv;
        sent = 0;
        while (sent < n_items) begin
            new_window();
            shape  = $urandom_range(0, 9);
            n_meas = $urandom_range(1, 10);
            n_conv = $urandom_range(1, 10);
            if (shape == 0) begin
                repeat (n_meas) send_pixel(1'($urandom()), 1'($urandom()), make_depth());
                sent += n_meas;
            end else begin
                // shape 1 keeps the previous frame going, shape 2 skips measuring
                if (shape != 2) begin
                    for (int i = 0; i < n_meas; i++) begin
                        send_pixel(OP_MEASURE, (i == 0) && (shape != 1), make_depth());
                    end
                    sent += n_meas;
                end
                for (int i = 0; i < n_conv; i++) begin
                    send_pixel(OP_CONVERT, $urandom_range(0, 3) == 0, make_depth());
                end
                sent += n_conv;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int p = 0; p < PHASES; p++) begin
            write_encoding((p % 2 == 0) ? ENC_MM : ENC_FLOAT);
            run_phase(PHASE_ITEMS);
            drain();
        end
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("depth_to_gray_normalizer_unit verification clean");
        end else begin
            $display("depth_to_gray_normalizer_unit verification failed");
        end
        $finish;
    end

endmodule
